>>> rtl/cpi_pkg.sv
package cpi_pkg;

  // start request into a serial arithmetic unit
  typedef struct packed {
    logic start;
  } cpi_req_t;

  // unit status back to the sequencer; done pulses one cycle with the result valid
  typedef struct packed {
    logic busy;
    logic done;
  } cpi_rsp_t;

endpackage

>>> rtl/cpi_mul.sv
module cpi_mul
  import cpi_pkg::*;
#(
  parameter int unsigned N = 36
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cpi_req_t       req_i,
  input  logic [N-1:0]   a_i,
  input  logic [N-1:0]   b_i,
  output cpi_rsp_t       rsp_o,
  output logic [2*N-1:0] prod_o
);

  localparam int unsigned CW = $clog2(N + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [2*N-1:0] acc_q, mc_q;
  logic [N-1:0]   mp_q;

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      mc_q  <= {{N{1'b0}}, a_i};
      mp_q  <= b_i;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

>>> rtl/cpi_sqrt.sv
module cpi_sqrt
  import cpi_pkg::*;
#(
  parameter int unsigned N = 36
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cpi_req_t       req_i,
  input  logic [2*N-1:0] rad_i,
  output cpi_rsp_t       rsp_o,
  output logic [N-1:0]   root_o
);

  localparam int unsigned CW = $clog2(N + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [N+2:0]  rem_q;
  logic [N-1:0]  root_q;
  logic [2*N-1:0] rad_q;

  logic [N+2:0] rem_sh, trial;
  logic         fit;

  // restoring square root, two radicand bits in, one root bit out per cycle
  assign rem_sh = {rem_q[N:0], rad_q[2*N-1:2*N-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fit    = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      root_q <= '0;
      rad_q  <= rad_i;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (fit) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[N-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[N-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign root_o     = root_q;

endmodule

>>> rtl/cpi_div.sv
module cpi_div
  import cpi_pkg::*;
#(
  parameter int unsigned NW = 72,
  parameter int unsigned DW = 36,
  parameter int unsigned QW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cpi_req_t      req_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output cpi_rsp_t      rsp_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(QW + 1);
  localparam int unsigned SW = DW + QW;
  localparam int unsigned XW = (NW > SW) ? NW : SW;

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] rem_q;
  logic [SW-1:0] dsh_q;
  logic [QW-1:0] q_q;

  logic [XW-1:0] rem_x, dsh_x, diff_x;
  logic          ge;

  // restoring division, one quotient bit per cycle from the top;
  // the caller guarantees the quotient fits QW bits
  assign rem_x  = XW'(rem_q);
  assign dsh_x  = XW'(dsh_q);
  assign ge     = (rem_x >= dsh_x);
  assign diff_x = rem_x - dsh_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= num_i;
      dsh_q <= SW'(den_i) << (QW - 1);
      q_q   <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff_x[NW-1:0];
      end
      q_q   <= {q_q[QW-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quot_o     = q_q;

endmodule

>>> rtl/circle_polyline_intersection.sv
// Circle / polyline intersection. Vertices stream in one per input beat with the circle
// (center, radius) on every beat; tuser marks the first vertex of a polyline, tlast the last.
// Each vertex closes a segment with the one before and the segment's crossings with the
// circle are found exactly in raw fixed-point units: a = |d|^2, h = d.e, c = |e|^2 - r^2,
// s = isqrt(h^2 - a*c), roots n = -h - s then -h + s kept when 0 <= n <= a, and the point
// P1 + trunc(n*d/a). The point with the smallest y (earliest on ties) is kept, and one result
// beat goes out on the last vertex: tuser = found, tdata = hit x/y (zero when not found).
// Zero-length segments are skipped; a single vertex or a negative discriminant finds nothing.
// Timing: one vertex at a time. A vertex that closes no segment goes straight to the end
// step; one that closes a segment runs nine products on a bit-serial multiplier, then a
// bit-serial square root, then per accepted root two more products and two serial
// divisions. The next vertex is taken while a result beat still waits on the output
// register.
module circle_polyline_intersection
  import cpi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: point_x, point_y, center_x, center_y, radius (COORD_WIDTH each), zero pad
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic [0:0] s_axis_tuser,            // first_vertex
  input  logic       s_axis_tlast,            // last_vertex
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  // tdata: hit_x, hit_y (COORD_WIDTH each), zero pad
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic [0:0] m_axis_tuser,            // found
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned MW  = 2 * W + 4;   // multiplier operand width
  localparam int unsigned SW  = MW + 2;      // signed working width of a, h, c, n
  localparam int unsigned PW  = 2 * MW;      // product width
  localparam int unsigned DDW = PW + 1;      // signed discriminant width
  localparam int unsigned QW  = W + 1;       // quotient width
  localparam int unsigned OW  = ((2 * W + 7) / 8) * 8;

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SETUP  = 4'd1;
  localparam logic [3:0] ST_MLOAD  = 4'd2;
  localparam logic [3:0] ST_MWAIT  = 4'd3;
  localparam logic [3:0] ST_DCHK   = 4'd4;
  localparam logic [3:0] ST_SQGO   = 4'd5;
  localparam logic [3:0] ST_SQWAIT = 4'd6;
  localparam logic [3:0] ST_ROOT   = 4'd7;
  localparam logic [3:0] ST_DVGO   = 4'd8;
  localparam logic [3:0] ST_DVWAIT = 4'd9;
  localparam logic [3:0] ST_FIN    = 4'd10;
  localparam logic [3:0] ST_EMIT   = 4'd11;

  // product steps on the shared multiplier
  localparam logic [3:0] MS_DXX = 4'd0;
  localparam logic [3:0] MS_DYY = 4'd1;
  localparam logic [3:0] MS_DXE = 4'd2;
  localparam logic [3:0] MS_DYE = 4'd3;
  localparam logic [3:0] MS_EXX = 4'd4;
  localparam logic [3:0] MS_EYY = 4'd5;
  localparam logic [3:0] MS_RR  = 4'd6;
  localparam logic [3:0] MS_HH  = 4'd7;
  localparam logic [3:0] MS_AC  = 4'd8;
  localparam logic [3:0] MS_NDX = 4'd9;
  localparam logic [3:0] MS_NDY = 4'd10;

  logic [3:0] state_q, step_q;
  logic       k_q, seg_q, last_q, neg_q;

  logic [W-1:0] px_q, py_q, cx_q, cy_q, r_q, x1_q, y1_q;
  logic [W-1:0] prev_x_q, prev_y_q, best_x_q, best_y_q;
  logic         have_prev_q, have_best_q;

  logic signed [SW-1:0]  dx_q, dy_q, ex_q, ey_q, a_q, h_q, c_q, n_q;
  logic signed [DDW-1:0] d_q;
  logic [MW-1:0] s_q;
  logic [PW-1:0] num_q;
  logic [QW-1:0] qx_q;

  logic [OW-1:0] out_data_q;
  logic          out_found_q, out_valid_q;

  cpi_req_t mul_req, sq_req, dv_req;
  cpi_rsp_t mul_rsp, sq_rsp, dv_rsp;
  logic [MW-1:0] mul_a, mul_b, sq_root;
  logic [PW-1:0] mul_prod;
  logic [QW-1:0] dv_quot;

  logic               in_acc;
  logic               first_in;
  logic               emit_go;
  logic signed [SW-1:0] dx_w, dy_w, ex_w, ey_w;
  logic signed [SW-1:0] opa, opb, ma_w, mb_w, s_ext, nv;
  logic signed [DDW-1:0] pext, sp;
  logic [QW-1:0]      hx_w, hy_w;
  logic               better;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign first_in = s_axis_tuser[0];
  assign s_axis_tready = (state_q == ST_IDLE);

  // result register loads in this cycle
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // segment vectors: d = P2 - P1, e = P1 - center
  assign dx_w = $signed({{(SW-W){px_q[W-1]}}, px_q}) - $signed({{(SW-W){x1_q[W-1]}}, x1_q});
  assign dy_w = $signed({{(SW-W){py_q[W-1]}}, py_q}) - $signed({{(SW-W){y1_q[W-1]}}, y1_q});
  assign ex_w = $signed({{(SW-W){x1_q[W-1]}}, x1_q}) - $signed({{(SW-W){cx_q[W-1]}}, cx_q});
  assign ey_w = $signed({{(SW-W){y1_q[W-1]}}, y1_q}) - $signed({{(SW-W){cy_q[W-1]}}, cy_q});

  // operand select; the multiplier works on magnitudes, sign applied afterwards
  always_comb begin
    case (step_q)
      MS_DXX:  begin opa = dx_q; opb = dx_q; end
      MS_DYY:  begin opa = dy_q; opb = dy_q; end
      MS_DXE:  begin opa = dx_q; opb = ex_q; end
      MS_DYE:  begin opa = dy_q; opb = ey_q; end
      MS_EXX:  begin opa = ex_q; opb = ex_q; end
      MS_EYY:  begin opa = ey_q; opb = ey_q; end
      MS_RR:   begin
        opa = $signed({{(SW-W){1'b0}}, r_q});
        opb = $signed({{(SW-W){1'b0}}, r_q});
      end
      MS_HH:   begin opa = h_q; opb = h_q; end
      MS_AC:   begin opa = a_q; opb = c_q; end
      MS_NDX:  begin opa = n_q; opb = dx_q; end
      MS_NDY:  begin opa = n_q; opb = dy_q; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign ma_w  = opa[SW-1] ? -opa : opa;
  assign mb_w  = opb[SW-1] ? -opb : opb;
  assign mul_a = ma_w[MW-1:0];
  assign mul_b = mb_w[MW-1:0];

  assign pext = $signed({1'b0, mul_prod});
  assign sp   = neg_q ? -pext : pext;

  // candidate root: first -h - s, then -h + s
  assign s_ext = $signed({{(SW-MW){1'b0}}, s_q});
  assign nv    = k_q ? (-h_q + s_ext) : (-h_q - s_ext);

  // point on the segment, offsets truncated toward zero
  assign hx_w = dx_q[SW-1] ? ({x1_q[W-1], x1_q} - qx_q) : ({x1_q[W-1], x1_q} + qx_q);
  assign hy_w = dy_q[SW-1] ? ({y1_q[W-1], y1_q} - dv_quot) : ({y1_q[W-1], y1_q} + dv_quot);
  assign better = !have_best_q || ($signed(hy_w[W-1:0]) < $signed(best_y_q));

  assign mul_req.start = (state_q == ST_MLOAD);
  assign sq_req.start  = (state_q == ST_SQGO);
  assign dv_req.start  = (state_q == ST_DVGO);

  cpi_mul #(.N(MW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .rsp_o  (mul_rsp),
    .prod_o (mul_prod)
  );

  cpi_sqrt #(.N(MW)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rad_i  (d_q[PW-1:0]),
    .rsp_o  (sq_rsp),
    .root_o (sq_root)
  );

  cpi_div #(.NW(PW), .DW(MW), .QW(QW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dv_req),
    .num_i  (num_q),
    .den_i  (a_q[MW-1:0]),
    .rsp_o  (dv_rsp),
    .quot_o (dv_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= MS_DXX;
      k_q         <= 1'b0;
      seg_q       <= 1'b0;
      last_q      <= 1'b0;
      neg_q       <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      r_q         <= '0;
      x1_q        <= '0;
      y1_q        <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      have_best_q <= 1'b0;
      dx_q        <= '0;
      dy_q        <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      a_q         <= '0;
      h_q         <= '0;
      c_q         <= '0;
      n_q         <= '0;
      d_q         <= '0;
      s_q         <= '0;
      num_q       <= '0;
      qx_q        <= '0;
      out_data_q  <= '0;
      out_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && !emit_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            px_q   <= s_axis_tdata[W-1:0];
            py_q   <= s_axis_tdata[2*W-1:W];
            cx_q   <= s_axis_tdata[3*W-1:2*W];
            cy_q   <= s_axis_tdata[4*W-1:3*W];
            r_q    <= s_axis_tdata[5*W-1:4*W];
            last_q <= s_axis_tlast;
            x1_q   <= prev_x_q;
            y1_q   <= prev_y_q;
            seg_q  <= have_prev_q && !first_in;
            prev_x_q    <= s_axis_tdata[W-1:0];
            prev_y_q    <= s_axis_tdata[2*W-1:W];
            have_prev_q <= 1'b1;
            if (first_in) begin
              have_best_q <= 1'b0;
              best_x_q    <= '0;
              best_y_q    <= '0;
            end
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          dx_q   <= dx_w;
          dy_q   <= dy_w;
          ex_q   <= ex_w;
          ey_q   <= ey_w;
          step_q <= MS_DXX;
          k_q    <= 1'b0;
          // zero-length segment or no held vertex: nothing to test
          if (!seg_q || (dx_w == '0 && dy_w == '0)) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_MLOAD;
          end
        end
        ST_MLOAD: begin
          neg_q   <= opa[SW-1] ^ opb[SW-1];
          state_q <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_rsp.done) begin
            step_q  <= step_q + 4'd1;
            state_q <= ST_MLOAD;
            case (step_q)
              MS_DXX: a_q <= sp[SW-1:0];
              MS_DYY: a_q <= a_q + sp[SW-1:0];
              MS_DXE: h_q <= sp[SW-1:0];
              MS_DYE: h_q <= h_q + sp[SW-1:0];
              MS_EXX: c_q <= sp[SW-1:0];
              MS_EYY: c_q <= c_q + sp[SW-1:0];
              MS_RR:  c_q <= c_q - sp[SW-1:0];
              MS_HH:  d_q <= sp;
              MS_AC: begin
                d_q     <= d_q - sp;
                state_q <= ST_DCHK;
              end
              default: begin
                // n*|d| for a root coordinate
                num_q   <= mul_prod;
                step_q  <= step_q;
                state_q <= ST_DVGO;
              end
            endcase
          end
        end
        ST_DCHK: begin
          state_q <= d_q[DDW-1] ? ST_FIN : ST_SQGO;
        end
        ST_SQGO: begin
          state_q <= ST_SQWAIT;
        end
        ST_SQWAIT: begin
          if (sq_rsp.done) begin
            s_q     <= sq_root;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (!nv[SW-1] && (nv <= a_q)) begin
            n_q     <= nv;
            step_q  <= MS_NDX;
            state_q <= ST_MLOAD;
          end else if (k_q) begin
            state_q <= ST_FIN;
          end else begin
            k_q <= 1'b1;
          end
        end
        ST_DVGO: begin
          state_q <= ST_DVWAIT;
        end
        ST_DVWAIT: begin
          if (dv_rsp.done) begin
            if (step_q == MS_NDX) begin
              qx_q    <= dv_quot;
              step_q  <= MS_NDY;
              state_q <= ST_MLOAD;
            end else begin
              if (better) begin
                best_x_q    <= hx_w[W-1:0];
                best_y_q    <= hy_w[W-1:0];
                have_best_q <= 1'b1;
              end
              if (k_q) begin
                state_q <= ST_FIN;
              end else begin
                k_q     <= 1'b1;
                state_q <= ST_ROOT;
              end
            end
          end
        end
        ST_FIN: begin
          state_q <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          // wait for the output register to free up
          if (emit_go) begin
            out_found_q <= have_best_q;
            out_data_q  <= have_best_q ? OW'({best_y_q, best_x_q}) : '0;
            out_valid_q <= 1'b1;
            have_best_q <= 1'b0;
            best_x_q    <= '0;
            best_y_q    <= '0;
            have_prev_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tvalid = out_valid_q;

  // an accepted vertex always starts a computation
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SETUP))
    else $error("vertex accepted without entering setup");

  // a new result beat only comes from the emit step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
    else $error("result beat raised outside emit");

  // not-found results carry zero coordinates
  a_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_data_q == '0))
    else $error("not-found result with nonzero point");

  // multiplier done follows a busy cycle
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> $past(mul_rsp.busy))
    else $error("multiplier done without run");

endmodule

>>> sim/tb_circle_polyline_intersection.sv
module tb_circle_polyline_intersection;
  timeunit 1ns;
  timeprecision 1ps;

  import cpi_pkg::*;

  localparam int CW         = 16;
  localparam int IDLE_LIMIT = 20000;  // cycles without any beat before giving up
  localparam int DRAIN_WAIT = 800;    // worst segment latency plus margin

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] px, py, cx, cy;
    logic [CW-1:0]        rad;
    logic                 first, last;
    logic                 hold;  // wait for all results before offering this beat
  } vertex_t;

  typedef struct {
    logic                 found;
    logic signed [CW-1:0] hx, hy;
  } hit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [79:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  always #5 clk_i = ~clk_i;

  circle_polyline_intersection #(.COORD_WIDTH(CW)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tdata,   // point_x, point_y, center_x, center_y, radius
    .s_axis_tuser,   // first_vertex
    .s_axis_tlast,   // last_vertex
    .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata,   // hit_x, hit_y
    .m_axis_tuser,   // found
    .m_axis_tvalid, .m_axis_tready
  );

  vertex_t vertex_q[$];
  hit_t    hit_q[$];
  vertex_t on_bus;
  int      n_sent, n_hits, n_found, n_errors, idle_cnt;

  // Polyline tracker state
  longint  prev_x, prev_y, best_x, best_y;
  bit      have_prev, have_best;

  // --------------------------------------------------------------------------
  // Predictor: exact integer math on raw fixed-point values
  // --------------------------------------------------------------------------
  function automatic wide_t isqrt_floor(wide_t d);
    wide_t rt, t, one;
    one = 1;
    rt  = 0;
    for (int b = 72; b >= 0; b--) begin
      t = rt | (one << b);
      if (t * t <= d) rt = t;
    end
    return rt;
  endfunction

  // step of length floor(n*|d|/a) along one axis, sign of d
  function automatic longint axis_step(wide_t n, longint d, wide_t a);
    wide_t m, q;
    m = (d < 0) ? -d : d;
    q = (n * m) / a;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic cross_segment(longint x1, longint y1, longint x2, longint y2,
                               longint cx, longint cy, longint r);
    wide_t dx, dy, ex, ey, a, h, c, disc, s, n;
    longint hx, hy;
    dx = x2 - x1;
    dy = y2 - y1;
    if (dx == 0 && dy == 0) return;  // degenerate segment
    ex   = x1 - cx;
    ey   = y1 - cy;
    a    = dx * dx + dy * dy;
    h    = dx * ex + dy * ey;
    c    = ex * ex + ey * ey - wide_t'(r) * wide_t'(r);
    disc = h * h - a * c;
    if (disc < 0) return;  // misses the circle
    s = isqrt_floor(disc);
    // near root first, so it wins a tie in y
    for (int k = 0; k < 2; k++) begin
      n = (k == 0) ? (-h - s) : (-h + s);
      if (n < 0 || n > a) continue;
      hx = x1 + axis_step(n, x2 - x1, a);
      hy = y1 + axis_step(n, y2 - y1, a);
      if (!have_best || hy < best_y) begin
        best_x    = hx;
        best_y    = hy;
        have_best = 1'b1;
      end
    end
  endtask

  task automatic track_vertex(vertex_t v);
    hit_t res;
    if (v.first) begin
      have_prev = 1'b0;
      have_best = 1'b0;
    end
    if (have_prev) cross_segment(prev_x, prev_y, v.px, v.py, v.cx, v.cy, longint'(v.rad));
    prev_x    = v.px;
    prev_y    = v.py;
    have_prev = 1'b1;
    if (v.last) begin
      res.found = have_best;
      res.hx    = have_best ? CW'(best_x) : '0;
      res.hy    = have_best ? CW'(best_y) : '0;
      hit_q     = {hit_q, res};
      have_prev = 1'b0;
      have_best = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [CW-1:0] clip(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return CW'(v);
  endfunction

  task automatic add_vertex(longint px, longint py, longint cx, longint cy, longint r,
                            bit first, bit last, bit hold = 1'b0);
    vertex_t v;
    v.px = clip(px); v.py = clip(py); v.cx = clip(cx); v.cy = clip(cy);
    v.rad = r[CW-1:0]; v.first = first; v.last = last; v.hold = hold;
    vertex_q = {vertex_q, v};
  endtask

  // well-formed polyline scattered around its circle, so crossings are common
  task automatic add_polyline(bit hold);
    int     nv;
    longint cx, cy, r, spread;
    nv = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
    r  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
    cx = $signed($urandom_range(0, 40000)) - 20000;
    cy = $signed($urandom_range(0, 40000)) - 20000;
    spread = 2 * r + 16;
    for (int i = 0; i < nv; i++)
      add_vertex(cx + $signed($urandom_range(0, 2 * spread)) - spread,
                 cy + $signed($urandom_range(0, 2 * spread)) - spread,
                 cx, cy, r, i == 0, i == nv - 1, hold && i == 0);
  endtask

  // any field value, any flags
  task automatic add_noise();
    add_vertex($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
               $signed(16'($urandom)), $urandom_range(0, 65535),
               $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  // --------------------------------------------------------------------------
  // Sender: one beat per handshake, random gaps, hold-off on marked beats
  // --------------------------------------------------------------------------
  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int phase_of(int n);
    return (n < 500) ? 0 : (n < 1000) ? 1 : 2;
  endfunction

  always @(posedge clk_i) begin
    bit      offer;
    vertex_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_vertex(on_bus);
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = vertex_q.size() > 0;
        if (offer && vertex_q[0].hold && hit_q.size() > 0) offer = 1'b0;
        if (offer && phase_of(n_sent) == 0 && roll(21)) offer = 1'b0;
        if (offer && phase_of(n_sent) == 1 && roll(50)) offer = 1'b0;
        if (offer) begin
          nxt    = vertex_q.pop_front();
          on_bus = nxt;
          s_axis_tdata <= {nxt.rad, nxt.cy, nxt.cx, nxt.py, nxt.px};
          s_axis_tuser <= nxt.first;
          s_axis_tlast <= nxt.last;
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random backpressure, compare each result beat in order
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hit_t exp_hit;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_hits++;
        if (hit_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result beat found=%0b data=%h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          exp_hit = hit_q.pop_front();
          if (exp_hit.found) n_found++;
          if (m_axis_tuser[0] !== exp_hit.found) begin
            n_errors++;
            $display("%0t: found expected %0b actual %0b", $time, exp_hit.found, m_axis_tuser);
          end
          if (m_axis_tdata[15:0] !== exp_hit.hx) begin
            n_errors++;
            $display("%0t: hit_x expected %0d actual %0d", $time, exp_hit.hx,
                     $signed(m_axis_tdata[15:0]));
          end
          if (m_axis_tdata[31:16] !== exp_hit.hy) begin
            n_errors++;
            $display("%0t: hit_y expected %0d actual %0d", $time, exp_hit.hy,
                     $signed(m_axis_tdata[31:16]));
          end
        end
      end
      case (phase_of(n_sent))
        0:       m_axis_tready <= !roll(50);
        1:       m_axis_tready <= !roll(21);
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Watchdog: counts cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d vertices sent, %0d results pending",
                 $time, n_sent, hit_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int total;
    // extremes of every coordinate, largest radius
    add_vertex(-32768, -32768, 0, 0, 65535, 1, 0);
    add_vertex(32767, 32767, 0, 0, 65535, 0, 0);
    add_vertex(-32768, 32767, -32768, 32767, 65535, 0, 1);
    // zero radius: segment through the center touches at one point
    add_vertex(-100, 0, 0, 0, 0, 1, 0);
    add_vertex(100, 0, 0, 0, 0, 0, 1);
    // tie in y: horizontal chord, near crossing must win
    add_vertex(-320, 0, 0, 0, 160, 1, 0);
    add_vertex(320, 0, 0, 0, 160, 0, 1);
    // lone vertex carrying both flags
    add_vertex(5, 5, 0, 0, 100, 1, 1);
    // zero-length segment, then a real one
    add_vertex(0, 500, 0, 0, 400, 1, 0);
    add_vertex(0, 500, 0, 0, 400, 0, 0);
    add_vertex(0, -500, 0, 0, 400, 0, 1);
    // wide miss (negative discriminant) and segment inside the circle
    add_vertex(1000, 1000, 0, 0, 50, 1, 0);
    add_vertex(2000, 1000, 0, 0, 50, 0, 0);
    add_vertex(-10, 2, 0, 0, 5000, 0, 0);
    add_vertex(10, -2, 0, 0, 5000, 0, 1);
    // no first flag after a finished polyline; circle changes mid-line
    add_vertex(-300, 40, 0, 0, 200, 0, 0, 1);
    add_vertex(300, 40, 0, 0, 200, 0, 0);
    add_vertex(300, -300, 300, 0, 100, 0, 0);
    // restart mid-line drops the kept point
    add_vertex(-300, -40, 0, 0, 200, 1, 0);
    add_vertex(300, -40, 0, 0, 200, 0, 1);

    total = vertex_q.size();
    while (total < 1500) begin
      if (roll(12)) begin
        add_noise();
      end else begin
        add_polyline((total / 200) != ((total + 8) / 200));
      end
      total = vertex_q.size() + 20 - 20;
    end
    // make sure the last polyline is closed
    add_vertex(0, 0, 0, 0, 10, 0, 1);
    total = vertex_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_sent == total && hit_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("run covered %0d vertices, %0d result beats checked (%0d with a hit)",
             n_sent, n_hits, n_found);
    $display("across sender gaps, receiver backpressure, restarts and degenerate segments");
    if (n_errors == 0 && hit_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cpi_pkg.sv
rtl/cpi_mul.sv
rtl/cpi_sqrt.sv
rtl/cpi_div.sv
rtl/circle_polyline_intersection.sv
sim/tb_circle_polyline_intersection.sv
